// ===== design/nnsp_pkg.sv =====
// shared types and constants for the nearest-neighbor shape parameter block
package nnsp_pkg;

    typedef enum logic [1:0] {
        STATUS_OK  = 2'd0,
        STATUS_LOW = 2'd1,
        STATUS_FEW = 2'd2
    } status_t;

    localparam logic REG_SCALE    = 1'b0;
    localparam logic REG_MIN_MEAN = 1'b1;

    localparam int CFG_W = 16;
    localparam int RES_W = 32;
    localparam int SHAPE_EXP = 48;
    localparam int SHAPE_MIN_DIVW = SHAPE_EXP + 1;

    localparam logic [CFG_W-1:0] SCALE_RESET    = 16'd53412;
    localparam logic [CFG_W-1:0] MIN_MEAN_RESET = 16'd1;

endpackage

// ===== design/nnsp_front.sv =====
// input stage: takes point transactions, trims coordinates, hands items to the queue
module nnsp_front #(
    parameter int CW = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [95:0]     s_data,
    input  logic            s_last,
    output logic            q_valid,
    input  logic            q_ready,
    output logic [3*CW:0]   q_item
);

    logic          valid_reg;
    logic          valid_next;
    logic [3*CW:0] item_reg;

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_ready)
        begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // keep only the low coordinate bits, sign comes from the top kept bit
    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            item_reg <= {s_last, s_data[64 +: CW], s_data[32 +: CW], s_data[0 +: CW]};
        end
    end

endmodule

// ===== design/nnsp_queue.sv =====
// short fifo between the input stage and the compute engine
module nnsp_queue #(
    parameter int W = 97
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    logic [W-1:0]  mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          push;
    logic          pop;

    assign push_ready = count_reg != (PW+1)'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/nnsp_div.sv =====
// restoring divider, one quotient bit per cycle
module nnsp_div #(
    parameter int DIVW = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [DIVW-1:0] dividend,
    input  logic [DIVW-1:0] divisor,
    output logic            done,
    output logic [DIVW-1:0] quotient
);

    localparam int CNTW = $clog2(DIVW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [DIVW:0]   rem_reg;
    logic [DIVW-1:0] quo_reg;
    logic [DIVW-1:0] dsr_reg;
    logic [DIVW:0]   rem_sh;
    logic            fits;

    assign rem_sh   = {rem_reg[DIVW-1:0], quo_reg[DIVW-1]};
    assign fits     = rem_sh >= {1'b0, dsr_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(DIVW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
            quo_reg <= {quo_reg[DIVW-2:0], fits};
        end
    end

endmodule

// ===== design/nnsp_back.sv =====
// compute engine: point store, nearest-neighbor scan, root, mean and shape parameter
module nnsp_back #(
    parameter int MAX_POINTS = 64,
    parameter int CW         = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  logic [3*CW:0]               pop_item,
    input  logic [nnsp_pkg::CFG_W-1:0]  scale_factor,
    input  logic [nnsp_pkg::CFG_W-1:0]  min_mean_distance,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [nnsp_pkg::RES_W-1:0]  out_shape,
    output logic [nnsp_pkg::RES_W-1:0]  out_mean,
    output nnsp_pkg::status_t           out_status
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CNTW  = $clog2(MAX_POINTS + 1);
    localparam int DW    = CW + 1;
    localparam int RTW   = CW + 2;
    localparam int SQW   = 2 * RTW;
    localparam int REMW  = RTW + 3;
    localparam int STEPW = $clog2(RTW + 1);
    localparam int SUMW  = RTW + CNTW;
    localparam int PRODW = SUMW + nnsp_pkg::CFG_W;
    localparam int DIVW  = PRODW > nnsp_pkg::SHAPE_MIN_DIVW ? PRODW : nnsp_pkg::SHAPE_MIN_DIVW;
    localparam int RW    = nnsp_pkg::RES_W;
    localparam logic [DIVW-1:0] SHAPE_NUM = DIVW'(1) << nnsp_pkg::SHAPE_EXP;

    typedef enum logic [11:0] {
        S_LOAD       = 12'b000000000001,
        S_ROW_RD     = 12'b000000000010,
        S_ROW_LD     = 12'b000000000100,
        S_SCAN       = 12'b000000001000,
        S_SQRT       = 12'b000000010000,
        S_ACC        = 12'b000000100000,
        S_MEAN_GO    = 12'b000001000000,
        S_MEAN_WAIT  = 12'b000010000000,
        S_MUL        = 12'b000100000000,
        S_SHAPE_GO   = 12'b001000000000,
        S_SHAPE_WAIT = 12'b010000000000,
        S_EMIT       = 12'b100000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [3*CW-1:0] mem [MAX_POINTS];
    logic [3*CW-1:0] rd_reg;
    logic [AW-1:0]   rd_addr;
    logic [3*CW-1:0] pi_reg;

    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] n_reg;
    logic [CNTW-1:0] i_reg;
    logic [CNTW-1:0] j_reg;
    logic            few_reg;
    logic            pop;
    logic            has_room;

    logic            p1_v_reg;
    logic            p1_skip_reg;
    logic            p2_v_reg;
    logic            p3_v_reg;
    logic [DW-1:0]   ad_reg [3];
    logic [2*DW-1:0] sq_reg [3];
    logic [SQW-1:0]  min_reg;
    logic [SQW-1:0]  sq_sum;
    logic [DW-1:0]   diff [3];
    logic            pipe_empty;

    logic [SQW-1:0]   val_reg;
    logic [REMW-1:0]  rem_reg;
    logic [RTW-1:0]   root_reg;
    logic [STEPW-1:0] step_reg;
    logic [REMW-1:0]  rem_sh;
    logic [REMW-1:0]  trial;
    logic             root_bit;

    logic [SUMW-1:0]  sum_reg;
    logic [SUMW-1:0]  mean_reg;
    logic [PRODW-1:0] prod_reg;
    logic [DIVW-1:0]  mean_wide;

    logic             div_start;
    logic [DIVW-1:0]  div_dividend;
    logic [DIVW-1:0]  div_divisor;
    logic             div_done;
    logic [DIVW-1:0]  div_quo;

    logic             out_valid_reg;
    logic [RW-1:0]    out_shape_reg;
    logic [RW-1:0]    out_mean_reg;
    nnsp_pkg::status_t out_status_reg;
    logic [RW-1:0]    shape_reg;

    assign pop_ready  = state_reg == S_LOAD;
    assign pop        = pop_valid && pop_ready;
    assign has_room   = cnt_reg < CNTW'(MAX_POINTS);
    assign pipe_empty = !p1_v_reg && !p2_v_reg && !p3_v_reg;
    assign rd_addr    = (state_reg == S_ROW_RD) ? i_reg[AW-1:0] : j_reg[AW-1:0];
    assign mean_wide  = DIVW'(mean_reg);

    assign out_valid  = out_valid_reg;
    assign out_shape  = out_shape_reg;
    assign out_mean   = out_mean_reg;
    assign out_status = out_status_reg;

    // signed coordinate differences against the row point, and the sum of the three squares
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff[k] = DW'($signed({pi_reg[k*CW + CW-1], pi_reg[k*CW +: CW]})
                        - $signed({rd_reg[k*CW + CW-1], rd_reg[k*CW +: CW]}));
        end
        sq_sum = SQW'(sq_reg[0]) + SQW'(sq_reg[1]) + SQW'(sq_reg[2]);
    end

    // two radicand bits and one result bit per step
    assign rem_sh   = {rem_reg[REMW-3:0], val_reg[SQW-1:SQW-2]};
    assign trial    = REMW'({root_reg, 2'b01});
    assign root_bit = rem_sh >= trial;

    assign div_start    = (state_reg == S_MEAN_GO) || (state_reg == S_SHAPE_GO && prod_reg != '0);
    assign div_dividend = (state_reg == S_MEAN_GO) ? DIVW'(sum_reg) : SHAPE_NUM;
    assign div_divisor  = (state_reg == S_MEAN_GO) ? DIVW'(n_reg) : DIVW'(prod_reg);

    nnsp_div #(
        .DIVW (DIVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (pop && pop_item[3*CW])
                begin
                    if ((cnt_reg + CNTW'(has_room)) < CNTW'(2))
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_ROW_RD;
                    end
                end
            end
            S_ROW_RD:    state_next = S_ROW_LD;
            S_ROW_LD:    state_next = S_SCAN;
            S_SCAN:
            begin
                if (j_reg == n_reg && pipe_empty)
                begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (step_reg == STEPW'(RTW - 1))
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:       state_next = (i_reg + 1'b1 == n_reg) ? S_MEAN_GO : S_ROW_RD;
            S_MEAN_GO:   state_next = S_MEAN_WAIT;
            S_MEAN_WAIT: state_next = div_done ? S_MUL : S_MEAN_WAIT;
            S_MUL:       state_next = S_SHAPE_GO;
            S_SHAPE_GO:  state_next = (prod_reg == '0) ? S_EMIT : S_SHAPE_WAIT;
            S_SHAPE_WAIT: state_next = div_done ? S_EMIT : S_SHAPE_WAIT;
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_LOAD;
                end
            end
            default:     state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            p3_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                if (pop_item[3*CW])
                begin
                    cnt_reg <= '0;
                end
                else if (has_room)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            p1_v_reg <= (state_reg == S_SCAN) && (j_reg != n_reg);
            p2_v_reg <= p1_v_reg && !p1_skip_reg;
            p3_v_reg <= p2_v_reg;
            if (state_reg == S_EMIT && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && has_room)
        begin
            mem[cnt_reg[AW-1:0]] <= pop_item[3*CW-1:0];
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop && pop_item[3*CW])
        begin
            n_reg   <= cnt_reg + CNTW'(has_room);
            few_reg <= (cnt_reg + CNTW'(has_room)) < CNTW'(2);
            i_reg   <= '0;
            sum_reg <= '0;
        end
        if (state_reg == S_ROW_LD)
        begin
            pi_reg  <= rd_reg;
            j_reg   <= '0;
            min_reg <= '1;
        end
        if (state_reg == S_SCAN && j_reg != n_reg)
        begin
            p1_skip_reg <= j_reg == i_reg;
            j_reg       <= j_reg + 1'b1;
        end
        for (int k = 0; k < 3; k++)
        begin
            ad_reg[k] <= diff[k][DW-1] ? (DW'(0) - diff[k]) : diff[k];
            sq_reg[k] <= ad_reg[k] * ad_reg[k];
        end
        if (p3_v_reg && sq_sum < min_reg)
        begin
            min_reg <= sq_sum;
        end
        if (state_reg == S_SCAN && state_next == S_SQRT)
        begin
            val_reg  <= min_reg;
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= '0;
        end
        if (state_reg == S_SQRT)
        begin
            val_reg  <= val_reg << 2;
            rem_reg  <= root_bit ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[RTW-2:0], root_bit};
            step_reg <= step_reg + 1'b1;
        end
        if (state_reg == S_ACC)
        begin
            sum_reg <= sum_reg + SUMW'(root_reg);
            i_reg   <= i_reg + 1'b1;
        end
        if (state_reg == S_MEAN_WAIT && div_done)
        begin
            mean_reg <= div_quo[SUMW-1:0];
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PRODW'(scale_factor) * PRODW'(mean_reg);
        end
        if (state_reg == S_SHAPE_GO)
        begin
            shape_reg <= '1;
        end
        if (state_reg == S_SHAPE_WAIT && div_done)
        begin
            shape_reg <= (|div_quo[DIVW-1:RW]) ? '1 : div_quo[RW-1:0];
        end
        if (state_reg == S_EMIT && (!out_valid_reg || out_ready))
        begin
            if (few_reg)
            begin
                out_shape_reg  <= '0;
                out_mean_reg   <= '0;
                out_status_reg <= nnsp_pkg::STATUS_FEW;
            end
            else
            begin
                out_shape_reg  <= shape_reg;
                out_mean_reg   <= (|mean_wide[DIVW-1:RW]) ? '1 : mean_wide[RW-1:0];
                out_status_reg <= (mean_wide < DIVW'(min_mean_distance))
                                  ? nnsp_pkg::STATUS_LOW : nnsp_pkg::STATUS_OK;
            end
        end
    end

endmodule

// ===== design/nearest_neighbor_shape_parameter_top.sv =====
// top level of the mean nearest-neighbor distance and shape parameter block
//
// points arrive on the s_axis channel, one coordinate triple per transaction;
// tlast marks the final point of a cloud and starts the computation
// an input register and a four-entry queue feed the compute engine, so the
// input side keeps taking points while a finished result waits on m_axis
// loading runs at one point per cycle; up to MAX_POINTS points are stored,
// further points of the same cloud are dropped
// after tlast the engine scans every stored pair through one read port of the
// point memory; per row a pipelined scan over all points, then a serial square
// root of CW + 2 result bits (CW = min(COORD_BITS, 32)); after the last row a
// serial division gives the mean and, unless the scaled mean is zero, a second
// one gives the shape parameter; the pair scan is the limiting part
// one result transaction per cloud: shape parameter and mean distance on tdata,
// status on tuser; it is held until m_axis_tready, and the engine waits for the
// output register before it writes the next result
// configuration writes on the cfg channel are always accepted and are meant for
// the idle block; reset clears all control state and restores register defaults
module nearest_neighbor_shape_parameter_top #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // point_x, point_y, point_z
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // shape_parameter, mean_distance
    output logic [1:0]  m_axis_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // coordinates narrower than 32 bits use only their low bits
    localparam int CW = COORD_BITS < 32 ? COORD_BITS : 32;
    localparam int IW = 3 * CW + 1;

    logic [nnsp_pkg::CFG_W-1:0] scale_reg;
    logic [nnsp_pkg::CFG_W-1:0] min_mean_reg;

    logic          fq_valid;
    logic          fq_ready;
    logic [IW-1:0] fq_item;
    logic          qb_valid;
    logic          qb_ready;
    logic [IW-1:0] qb_item;

    logic [nnsp_pkg::RES_W-1:0] res_shape;
    logic [nnsp_pkg::RES_W-1:0] res_mean;
    nnsp_pkg::status_t          res_status;

    assign cfg_ready = 1'b1;

    // register file: scale factor and overlap threshold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg    <= nnsp_pkg::SCALE_RESET;
            min_mean_reg <= nnsp_pkg::MIN_MEAN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                nnsp_pkg::REG_SCALE:    scale_reg    <= cfg_data;
                nnsp_pkg::REG_MIN_MEAN: min_mean_reg <= cfg_data;
                default:                scale_reg    <= scale_reg;
            endcase
        end
    end

    nnsp_front #(
        .CW (CW)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_data  (s_axis_tdata),
        .s_last  (s_axis_tlast),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_item  (fq_item)
    );

    nnsp_queue #(
        .W (IW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_item)
    );

    nnsp_back #(
        .MAX_POINTS (MAX_POINTS),
        .CW         (CW)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .pop_valid         (qb_valid),
        .pop_ready         (qb_ready),
        .pop_item          (qb_item),
        .scale_factor      (scale_reg),
        .min_mean_distance (min_mean_reg),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_shape         (res_shape),
        .out_mean          (res_mean),
        .out_status        (res_status)
    );

    assign m_axis_tdata = {res_mean, res_shape};
    assign m_axis_tuser = res_status;

endmodule

// ===== design/nnsp_checker.sv =====
// port-level checks for the shape parameter block, bound to the top level
module nnsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a result stays offered until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a cloud with too few points carries zero values
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == nnsp_pkg::STATUS_FEW |-> m_axis_tdata == 64'd0)
        else $error("few-point result carries data");

    // zero mean distance gives the saturated shape parameter
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != nnsp_pkg::STATUS_FEW && m_axis_tdata[63:32] == 32'd0
        |-> m_axis_tdata[31:0] == 32'hFFFFFFFF)
        else $error("zero mean without saturated shape parameter");

endmodule

bind nearest_neighbor_shape_parameter_top nnsp_checker u_nnsp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
